### rtl/core/am3s_pkg.sv
// ----------------------------------------------------------------------------
// am3s_pkg
// shared types and constants for the character-driven median-of-three unit
// ----------------------------------------------------------------------------
package am3s_pkg;

  localparam int unsigned MAX_CHARS_DEF = 11;

  localparam logic [7:0] END_CHAR_RST   = 8'd101;
  localparam logic [7:0] CLEAR_CHAR_RST = 8'd70;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_END_CHAR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_CHAR = 2'd1;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam logic [1:0] FILL_FULL = 2'd3;

  // what one character does to the pending number
  typedef struct packed {
    logic               clear;
    logic               close;
    logic signed [31:0] value;
  } am3s_evt_t;

  // history snapshot after a closed number
  typedef struct packed {
    logic               valid;
    logic        [1:0]  fill;
    logic signed [31:0] value;
    logic signed [31:0] h0;
    logic signed [31:0] h1;
    logic signed [31:0] h2;
  } am3s_hist_t;

endpackage

### rtl/core/ascii_int_median3_sum_unit.sv
// ----------------------------------------------------------------------------
// ascii_int_median3_sum_unit
// decimal numbers typed one character a beat, kept in a three-deep history;
// each closed number returns its value with the history sum and median
// ----------------------------------------------------------------------------
//   channel | signals                               | direction
//   --------+---------------------------------------+----------
//   in      | in_valid, in_ready, char_code         | sink
//   out     | out_valid, out_ready, entered_value,  | source
//           | history_sum, history_median,          |
//           | filled_count                          |
//   cfg     | cfg_wr_en, cfg_index, cfg_data        | sink
//
// one character per cycle while no result is stalled; a closing character passes
// through the input register, parse/history stage and sum/median result register
// reset clears history, pending number and pipeline, end/clear to 'e' and 'F'
// a stalled result freezes the whole pipeline; in_ready is low only while a
// result waits and out_ready is low
// ----------------------------------------------------------------------------
module ascii_int_median3_sum_unit #(
  parameter int unsigned MAX_CHARS = am3s_pkg::MAX_CHARS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [am3s_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]                        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        char_code,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                entered_value,
  output logic signed [33:0]                history_sum,
  output logic signed [31:0]                history_median,
  output logic [1:0]                        filled_count
);
  import am3s_pkg::*;

  logic       adv;
  logic       step;
  logic [7:0] end_char;
  logic [7:0] clear_char;
  logic       s1_valid;
  logic [7:0] s1_char;

  am3s_evt_t  evt;
  am3s_hist_t hist;

  logic signed [31:0] h0;
  logic signed [31:0] h1;
  logic signed [31:0] h2;
  logic [1:0]         fill;
  logic signed [31:0] h0_next;
  logic signed [31:0] h1_next;
  logic signed [31:0] h2_next;
  logic [1:0]         fill_next;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign step     = adv && s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      end_char   <= END_CHAR_RST;
      clear_char <= CLEAR_CHAR_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_END_CHAR:   end_char   <= cfg_data;
        REG_CLEAR_CHAR: clear_char <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_char <= char_code;
    end
  end

  am3s_parser #(
    .MAX_CHARS (MAX_CHARS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .char_code  (s1_char),
    .end_char   (end_char),
    .clear_char (clear_char),
    .evt        (evt)
  );

  // history shift
  always_comb begin
    h0_next   = h0;
    h1_next   = h1;
    h2_next   = h2;
    fill_next = fill;
    if (evt.clear) begin
      h0_next   = '0;
      h1_next   = '0;
      h2_next   = '0;
      fill_next = '0;
    end else if (evt.close) begin
      h0_next   = h1;
      h1_next   = h2;
      h2_next   = evt.value;
      fill_next = (fill == FILL_FULL) ? FILL_FULL : fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h0   <= '0;
      h1   <= '0;
      h2   <= '0;
      fill <= '0;
    end else if (step) begin
      h0   <= h0_next;
      h1   <= h1_next;
      h2   <= h2_next;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist.valid <= 1'b0;
    end else if (adv) begin
      hist.valid <= step && evt.close;
    end
    if (adv) begin
      hist.fill  <= fill_next;
      hist.value <= evt.value;
      hist.h0    <= h0_next;
      hist.h1    <= h1_next;
      hist.h2    <= h2_next;
    end
  end

  am3s_stats u_stats (
    .clk            (clk),
    .rst            (rst),
    .adv            (adv),
    .hist           (hist),
    .out_valid      (out_valid),
    .entered_value  (entered_value),
    .history_sum    (history_sum),
    .history_median (history_median),
    .filled_count   (filled_count)
  );

`ifndef ASSERT_OFF
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while a result is stalled");

  a_close_makes_result: assert property (@(posedge clk) disable iff (rst)
    step && evt.close |=> hist.valid)
    else $error("closed number lost before the result stage");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    step && evt.clear |=> fill == 2'd0 && h2 == 32'sd0)
    else $error("clear did not empty the history");

  a_result_has_entries: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> filled_count != 2'd0)
    else $error("result with an empty history");

  a_single_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && filled_count == 2'd1 |->
      history_median == entered_value && history_sum == 34'(entered_value))
    else $error("single entry sum or median differs from the value");
`endif

endmodule

### rtl/core/am3s_parser.sv
// ----------------------------------------------------------------------------
// am3s_parser
// incremental decimal parser: whitespace, optional sign, digits, saturation
// ----------------------------------------------------------------------------
module am3s_parser #(
  parameter int unsigned MAX_CHARS = am3s_pkg::MAX_CHARS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           char_code,
  input  logic [7:0]           end_char,
  input  logic [7:0]           clear_char,
  output am3s_pkg::am3s_evt_t  evt
);
  import am3s_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_CHARS + 1);

  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_NUM  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7fff_ffff;

  logic [CNT_W-1:0] char_count;
  logic [CNT_W-1:0] char_count_next;
  logic [1:0]       parse_phase;
  logic [1:0]       parse_phase_next;
  logic             is_negative;
  logic             is_negative_next;
  logic [31:0]      accum_value;
  logic [31:0]      accum_value_next;

  logic        is_digit;
  logic        is_space;
  logic        is_sign;
  logic        full;
  logic        collect;
  logic [35:0] prod;
  logic [31:0] accum_step;

  always_comb begin
    is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    is_space = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
    is_sign  = (char_code == CH_PLUS) || (char_code == CH_MINUS);
    full     = (char_count >= CNT_W'(MAX_CHARS));

    evt.clear = (char_code == clear_char);
    evt.close = !evt.clear && ((char_code == end_char) || full);
    collect   = !evt.clear && !evt.close;

    // accum * 10 + digit, saturated at 2^31
    prod = ({4'd0, accum_value} << 3) + ({4'd0, accum_value} << 1) + {32'd0, char_code[3:0]};
    accum_step = (prod > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : prod[31:0];

    if (is_negative) begin
      evt.value = -$signed(accum_value);
    end else if (accum_value[31]) begin
      evt.value = $signed(POS_MAX);
    end else begin
      evt.value = $signed(accum_value);
    end

    char_count_next  = char_count;
    parse_phase_next = parse_phase;
    is_negative_next = is_negative;
    accum_value_next = accum_value;

    if (evt.clear || evt.close) begin
      char_count_next  = '0;
      parse_phase_next = PH_LEAD;
      is_negative_next = 1'b0;
      accum_value_next = '0;
    end else if (collect) begin
      char_count_next = char_count + 1'b1;
      unique case (parse_phase)
        PH_LEAD: begin
          if (is_space) begin
            parse_phase_next = PH_LEAD;
          end else if (is_sign) begin
            is_negative_next = (char_code == CH_MINUS);
            parse_phase_next = PH_NUM;
          end else if (is_digit) begin
            parse_phase_next = PH_NUM;
            accum_value_next = accum_step;
          end else begin
            parse_phase_next = PH_DONE;
          end
        end
        PH_NUM: begin
          if (is_digit) begin
            accum_value_next = accum_step;
          end else begin
            parse_phase_next = PH_DONE;
          end
        end
        default: begin
          parse_phase_next = parse_phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count  <= '0;
      parse_phase <= PH_LEAD;
      is_negative <= 1'b0;
      accum_value <= '0;
    end else if (step) begin
      char_count  <= char_count_next;
      parse_phase <= parse_phase_next;
      is_negative <= is_negative_next;
      accum_value <= accum_value_next;
    end
  end

endmodule

### rtl/core/am3s_stats.sv
// ----------------------------------------------------------------------------
// am3s_stats
// sum and median of the filled history entries, into the result register
// ----------------------------------------------------------------------------
module am3s_stats (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  am3s_pkg::am3s_hist_t  hist,
  output logic                  out_valid,
  output logic signed [31:0]    entered_value,
  output logic signed [33:0]    history_sum,
  output logic signed [31:0]    history_median,
  output logic [1:0]            filled_count
);
  import am3s_pkg::*;

  logic signed [33:0] a;
  logic signed [33:0] b;
  logic signed [33:0] c;
  logic signed [33:0] sum_bc;
  logic signed [33:0] sum_abc;
  logic signed [33:0] sum_sel;
  logic signed [33:0] half_adj;
  logic signed [33:0] half;
  logic signed [31:0] lo_ab;
  logic signed [31:0] hi_ab;
  logic signed [31:0] mid_hc;
  logic signed [31:0] med3;
  logic signed [31:0] med_sel;

  always_comb begin
    a       = 34'(hist.h0);
    b       = 34'(hist.h1);
    c       = 34'(hist.h2);
    sum_bc  = b + c;
    sum_abc = sum_bc + a;

    // mean of two, truncated toward zero
    half_adj = sum_bc + {33'd0, sum_bc[33]};
    half     = half_adj >>> 1;

    lo_ab  = (hist.h0 < hist.h1) ? hist.h0 : hist.h1;
    hi_ab  = (hist.h0 < hist.h1) ? hist.h1 : hist.h0;
    mid_hc = (hi_ab < hist.h2) ? hi_ab : hist.h2;
    med3   = (lo_ab > mid_hc) ? lo_ab : mid_hc;

    case (hist.fill)
      2'd1: begin
        sum_sel = c;
        med_sel = hist.h2;
      end
      2'd2: begin
        sum_sel = sum_bc;
        med_sel = half[31:0];
      end
      default: begin
        sum_sel = sum_abc;
        med_sel = med3;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= hist.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      entered_value  <= hist.value;
      history_sum    <= sum_sel;
      history_median <= med_sel;
      filled_count   <= hist.fill;
    end
  end

endmodule

### dv/ascii_int_median3_sum_unit_tb.sv
// ----------------------------------------------------------------------------
// ascii_int_median3_sum_unit_tb
// Drives character beats into the median-of-three unit and checks every result
// beat against a cycle-free predictor of the atoi-style parse and the
// three-deep history. A short directed opening covers whitespace, signs, stray
// codes, empty numbers, saturation and closing on a full collection. Random
// phases follow, each with its own end/clear setting; they vary the sender
// gaps and receiver stalls, and two of them run with neither.
// ----------------------------------------------------------------------------
module ascii_int_median3_sum_unit_tb;
  import am3s_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEN     = MAX_CHARS_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_CHARS = 160;

  typedef enum logic [1:0] {SCAN_LEAD, SCAN_NUM, SCAN_DONE} scan_phase_t;

  typedef struct {
    logic signed [31:0] value;
    logic signed [33:0] total;
    logic signed [31:0] median;
    logic        [1:0]  depth;
  } hist_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           char_code = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [31:0]   entered_value;
  logic signed [33:0]   history_sum;
  logic signed [31:0]   history_median;
  logic [1:0]           filled_count;

  // stimulus and expected results
  logic [7:0]   char_q[$];
  hist_result_t hist_results_q[$];
  int unsigned  chars_queued = 0;
  int unsigned  gap_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  mismatch_cnt = 0;
  int unsigned  cycle_cnt = 0;

  // predictor state
  logic [7:0]         end_sym = END_CHAR_RST;
  logic [7:0]         clear_sym = CLEAR_CHAR_RST;
  logic signed [31:0] hist[3] = '{0, 0, 0};
  logic [1:0]         hist_depth = '0;
  int unsigned        char_cnt = 0;
  scan_phase_t        scan = SCAN_LEAD;
  logic               minus_seen = 1'b0;
  logic [31:0]        magnitude = '0;

  ascii_int_median3_sum_unit #(
    .MAX_CHARS(MAX_LEN)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_code(char_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .entered_value(entered_value),
    .history_sum(history_sum),
    .history_median(history_median),
    .filled_count(filled_count)
  );

  always #10 clk = ~clk;

  function automatic void drop_pending();
    char_cnt   = 0;
    scan       = SCAN_LEAD;
    minus_seen = 1'b0;
    magnitude  = '0;
  endfunction

  function automatic void scan_char(logic [7:0] c);
    logic        is_digit;
    logic [63:0] grown;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (scan == SCAN_LEAD) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        minus_seen = (c == CH_MINUS);
        scan = SCAN_NUM;
        return;
      end
      scan = is_digit ? SCAN_NUM : SCAN_DONE;
    end
    if (scan == SCAN_NUM) begin
      if (is_digit) begin
        grown = {32'd0, magnitude} * 64'd10 + 64'(c) - 64'(CH_ZERO);
        magnitude = (grown > 64'h8000_0000) ? 32'h8000_0000 : grown[31:0];
      end else begin
        scan = SCAN_DONE;
      end
    end
  endfunction

  function automatic logic signed [31:0] mid_of_three(logic signed [31:0] a,
                                                      logic signed [31:0] b,
                                                      logic signed [31:0] c);
    if ((a >= b && a <= c) || (a >= c && a <= b)) return a;
    if ((b >= a && b <= c) || (b >= c && b <= a)) return b;
    return c;
  endfunction

  // one accepted character beat
  task automatic take_char(logic [7:0] c);
    hist_result_t       r;
    logic signed [31:0] v;
    longint             pair;
    if (c == clear_sym) begin
      hist = '{0, 0, 0};
      hist_depth = '0;
      drop_pending();
    end else if (c != end_sym && char_cnt < MAX_LEN) begin
      char_cnt++;
      scan_char(c);
    end else begin
      if (magnitude >= 32'h8000_0000)
        v = minus_seen ? 32'sh8000_0000 : 32'sh7fff_ffff;
      else
        v = minus_seen ? -$signed(magnitude) : $signed(magnitude);
      drop_pending();
      hist[0] = hist[1];
      hist[1] = hist[2];
      hist[2] = v;
      if (hist_depth != FILL_FULL) hist_depth++;
      r.value = v;
      r.depth = hist_depth;
      case (hist_depth)
        2'd1: begin
          r.total  = 34'(longint'(hist[2]));
          r.median = hist[2];
        end
        2'd2: begin
          pair     = longint'(hist[1]) + longint'(hist[2]);
          r.total  = 34'(pair);
          r.median = 32'(pair / 2);
        end
        default: begin
          r.total  = 34'(longint'(hist[0]) + longint'(hist[1]) + longint'(hist[2]));
          r.median = mid_of_three(hist[0], hist[1], hist[2]);
        end
      endcase
      hist_results_q.push_back(r);
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      char_code <= '0;
    end else begin
      if (in_valid && in_ready) take_char(char_code);
      if (!in_valid || in_ready) begin
        if (char_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          in_valid  <= 1'b1;
          char_code <= char_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    hist_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (hist_results_q.size() == 0) begin
          $error("result beat with nothing expected: value %0d", entered_value);
          mismatch_cnt++;
        end else begin
          want = hist_results_q.pop_front();
          if (entered_value !== want.value) begin
            $error("entered_value: expected %0d, got %0d", want.value, entered_value);
            mismatch_cnt++;
          end
          if (history_sum !== want.total) begin
            $error("history_sum: expected %0d, got %0d", want.total, history_sum);
            mismatch_cnt++;
          end
          if (history_median !== want.median) begin
            $error("history_median: expected %0d, got %0d", want.median, history_median);
            mismatch_cnt++;
          end
          if (filled_count !== want.depth) begin
            $error("filled_count: expected %0d, got %0d", want.depth, filled_count);
            mismatch_cnt++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void add_char(logic [7:0] c);
    char_q.push_back(c);
    chars_queued++;
  endfunction

  function automatic logic [7:0] stray_byte(bit keep_end);
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == clear_sym || (!keep_end && c == end_sym));
    return c;
  endfunction

  // a well-formed number with random content, closed by the end code or by
  // filling the collection; an end code equal to the clear code clears it
  function automatic bit queue_number();
    int unsigned used, n_dig, w;
    bit          by_fill;
    used = 0;
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        w = $urandom_range(5);
        add_char(w == 5 ? CH_SPACE : CH_TAB + 8'(w));
        used++;
      end
    end
    if ($urandom_range(2) == 0) begin
      add_char($urandom_range(1) ? CH_MINUS : CH_PLUS);
      used++;
    end
    n_dig = ($urandom_range(7) == 0) ? $urandom_range(10, 11) : $urandom_range(1, 6);
    if (n_dig > MAX_LEN - used) n_dig = MAX_LEN - used;
    repeat (n_dig) begin
      add_char(CH_ZERO + 8'($urandom_range(9)));
      used++;
    end
    if ($urandom_range(7) == 0 && used < MAX_LEN) begin
      add_char(stray_byte(1'b0));
      used++;
    end
    by_fill = ($urandom_range(3) == 0);
    if (by_fill) begin
      while (used < MAX_LEN) begin
        add_char(stray_byte(1'b0));
        used++;
      end
      add_char(stray_byte(1'b1));
    end else begin
      add_char(end_sym);
    end
    return by_fill || (end_sym != clear_sym);
  endfunction

  task automatic run_traffic();
    int unsigned first, closes, pick;
    first  = chars_queued;
    closes = 0;
    while (chars_queued - first < PHASE_CHARS || closes < 5) begin
      pick = $urandom_range(99);
      if (pick < 80)      closes += queue_number();
      else if (pick < 95) add_char(8'($urandom_range(255)));
      else                add_char(clear_sym);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (char_q.size() != 0 || in_valid || hist_results_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_END_CHAR) end_sym = val;
    else if (idx == REG_CLEAR_CHAR) clear_sym = val;
  endtask

  // drain, let the pipeline settle, then reprogram with the unit idle
  task automatic set_codes(logic [7:0] e, logic [7:0] c, bit poke_unused);
    wait_drained();
    repeat (8) @(posedge clk);
    write_reg(REG_END_CHAR, e);
    write_reg(REG_CLEAR_CHAR, c);
    if (poke_unused) begin
      write_reg(2'd2, 8'($urandom_range(255)));
      write_reg(2'd3, 8'($urandom_range(255)));
    end
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [7:0] opening[$];
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // whitespace lead-in, sign with stray high code, empty number, then a
    // negative overflow closed by a full collection, then clear
    opening = '{CH_CR, CH_TAB, CH_SPACE, CH_ZERO + 8'd7, END_CHAR_RST,
                CH_PLUS, CH_ZERO + 8'd5, 8'hff, CH_ZERO + 8'd3, END_CHAR_RST,
                8'h00, END_CHAR_RST,
                CH_MINUS, CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_NINE,
                CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_NINE,
                CLEAR_CHAR_RST};
    foreach (opening[k]) add_char(opening[k]);

    set_codes(8'h00, 8'hff, 1'b0);
    run_traffic();

    set_codes(8'hff, 8'h00, 1'b1);
    gap_pct = 55;
    run_traffic();

    // clear and end on the same code
    set_codes(8'd120, 8'd120, 1'b0);
    gap_pct   = 0;
    stall_pct = 55;
    run_traffic();

    set_codes(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
    gap_pct   = 10;
    stall_pct = 10;
    run_traffic();

    set_codes(END_CHAR_RST, CLEAR_CHAR_RST, 1'b0);
    gap_pct   = 0;
    stall_pct = 0;
    run_traffic();

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && hist_results_q.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
